[rtl/core/srrw_pkg.sv]
// ----------------------------------------------------------------------------
// srrw_pkg
// Shared types and constants of the selective-repeat receive window.
// ----------------------------------------------------------------------------
package srrw_pkg;

  localparam int WINDOW_SLOTS_DEF = 32;
  localparam int TAG_BITS_DEF     = 16;

  localparam int SEQ_W    = 8;
  localparam int WIN_W    = 5;
  localparam int STAMP_W  = 32;
  localparam int TAG_PORT_W = 16;
  localparam int KIND_W   = 2;

  localparam logic [WIN_W-1:0] MAX_WINDOW_RST = 5'd3;

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic REG_MAX_WINDOW = 1'b0;

  localparam logic [KIND_W-1:0] KIND_DELIVER = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ACK     = 2'd1;
  localparam logic [KIND_W-1:0] KIND_NACK    = 2'd2;
  localparam logic [KIND_W-1:0] KIND_END     = 2'd3;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_EVAL  = 6'b000010,
    S_END   = 6'b000100,
    S_DELIV = 6'b001000,
    S_WALK  = 6'b010000,
    S_ACK   = 6'b100000
  } srrw_state_t;

  typedef struct packed {
    logic load;
    logic shift;
    logic clear;
  } srrw_cell_ctrl_t;

endpackage

[rtl/core/srrw_channels.sv]
// ----------------------------------------------------------------------------
// srrw channels
// Packet header channel and result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface srrw_in_if;
  import srrw_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  well_formed;
  logic [SEQ_W-1:0]      seq;
  logic                  empty_req;
  logic                  truncated;
  logic [WIN_W-1:0]      peer_window;
  logic [STAMP_W-1:0]    stamp;
  logic [TAG_PORT_W-1:0] payload_tag;

  modport source (
    output valid, well_formed, seq, empty_req, truncated, peer_window, stamp,
           payload_tag,
    input  ready
  );
  modport sink (
    input  valid, well_formed, seq, empty_req, truncated, peer_window, stamp,
           payload_tag,
    output ready
  );
endinterface

interface srrw_out_if;
  import srrw_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [KIND_W-1:0]     kind;
  logic [SEQ_W-1:0]      out_seq;
  logic [TAG_PORT_W-1:0] out_tag;
  logic [WIN_W-1:0]      out_window;
  logic [STAMP_W-1:0]    out_stamp;
  logic                  last;

  modport source (
    output valid, kind, out_seq, out_tag, out_window, out_stamp, last,
    input  ready
  );
  modport sink (
    input  valid, kind, out_seq, out_tag, out_window, out_stamp, last,
    output ready
  );
endinterface

[rtl/core/srrw_cell.sv]
// ----------------------------------------------------------------------------
// srrw_cell
// One receive slot: full flag and buffer tag, loaded from a new packet or
// taken from the next slot up when the window slides, or cleared when it shrinks.
// ----------------------------------------------------------------------------
module srrw_cell #(
  parameter int TAG_BITS = srrw_pkg::TAG_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  srrw_pkg::srrw_cell_ctrl_t ctrl,
  input  logic [TAG_BITS-1:0]      load_tag,
  input  logic                     up_full,
  input  logic [TAG_BITS-1:0]      up_tag,
  output logic                     full,
  output logic [TAG_BITS-1:0]      tag
);
  import srrw_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (ctrl.load) begin
      full <= 1'b1;
    end else if (ctrl.shift) begin
      full <= up_full;
    end else if (ctrl.clear) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      tag <= load_tag;
    end else if (ctrl.shift) begin
      tag <= up_tag;
    end
  end

endmodule

[rtl/core/selective_repeat_receive_window_unit.sv]
// ----------------------------------------------------------------------------
// selective_repeat_receive_window_unit
// Receive window of a selective-repeat link. Packet headers enter on in_ch;
// deliveries, acks, nacks and the connection end leave on out_ch, one result
// per request. max_window is set through the APB port at address 0.
//
// A header is taken when in_ch.valid and in_ch.ready are high; ready is high
// only while no header is in work. The header is checked in the next cycle.
// A packet ahead of the expected one is stored in its slot and acked; the
// expected packet is delivered, then the held slots behind it are walked
// through the slot chain, one delivery per cycle while out_ch takes them,
// and an ack follows. Each delivery shifts the chain down by one slot; a
// delivery run ends in a walk step that emits nothing. Ignored headers go
// back to idle straight from the check.
// Results sit in an output register; a stalled out_ch holds it and the
// sequencer waits, while a new header is taken once the last result is loaded.
// Reset empties every slot, sets the expected sequence to 0, window and
// max_window to 3, and opens the connection.
// ----------------------------------------------------------------------------
module selective_repeat_receive_window_unit #(
  parameter int WINDOW_SLOTS = srrw_pkg::WINDOW_SLOTS_DEF,
  parameter int TAG_BITS     = srrw_pkg::TAG_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  srrw_in_if.sink                           in_ch,
  srrw_out_if.source                        out_ch,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [srrw_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [srrw_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [srrw_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready
);
  import srrw_pkg::*;

  localparam int DW = $clog2(WINDOW_SLOTS + 1);

  logic [WIN_W-1:0]   max_window;
  logic [SEQ_W-1:0]   expected_seq;
  logic [WIN_W-1:0]   cur_window;
  logic               closed;
  srrw_state_t        state;
  logic [DW-1:0]      d;
  logic               is_nack;

  logic               cap_wf;
  logic [SEQ_W-1:0]   cap_seq;
  logic               cap_empty;
  logic               cap_trunc;
  logic [WIN_W-1:0]   cap_pw;
  logic [STAMP_W-1:0] cap_stamp;
  logic [TAG_BITS-1:0] cap_tag;

  logic                  ov;
  logic [KIND_W-1:0]     o_kind;
  logic [SEQ_W-1:0]      o_seq;
  logic [TAG_PORT_W-1:0] o_tag;
  logic [STAMP_W-1:0]    o_stamp;
  logic                  o_last;

  logic                  emit_req;
  logic                  emit_fire;
  logic [KIND_W-1:0]     emit_kind;
  logic [SEQ_W-1:0]      emit_seq;
  logic [TAG_PORT_W-1:0] emit_tag;
  logic [STAMP_W-1:0]    emit_stamp;
  logic                  emit_last;

  logic [SEQ_W-1:0]   off;
  logic               in_window;
  logic               walk_more;
  logic               do_shift;
  logic               store_base;
  logic               ack_fire;
  logic               shrink;

  srrw_cell_ctrl_t     ctrl     [WINDOW_SLOTS];
  logic                cell_full [WINDOW_SLOTS];
  logic [TAG_BITS-1:0] cell_tag  [WINDOW_SLOTS];

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_MAX_WINDOW) ?
                  APB_DATA_W'(max_window) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_window <= MAX_WINDOW_RST;
    end else if (psel && penable && pwrite && (paddr[2] == REG_MAX_WINDOW)) begin
      max_window <= pwdata[WIN_W-1:0];
    end
  end

  assign in_ch.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      cap_wf    <= in_ch.well_formed;
      cap_seq   <= in_ch.seq;
      cap_empty <= in_ch.empty_req;
      cap_trunc <= in_ch.truncated;
      cap_pw    <= in_ch.peer_window;
      cap_stamp <= in_ch.stamp;
      cap_tag   <= TAG_BITS'(in_ch.payload_tag);
    end
  end

  assign off       = cap_seq - expected_seq;
  assign in_window = (off == '0) ||
                     ((32'(off) < 32'(cur_window)) && (32'(off) < WINDOW_SLOTS));
  assign walk_more = (32'(d) < 32'(cur_window)) && (32'(d) < WINDOW_SLOTS) &&
                     cell_full[0];

  always_comb begin
    emit_req   = 1'b0;
    emit_kind  = KIND_ACK;
    emit_seq   = expected_seq;
    emit_tag   = '0;
    emit_stamp = '0;
    emit_last  = 1'b0;
    unique case (state)
      S_END: begin
        emit_req  = 1'b1;
        emit_kind = KIND_END;
        emit_seq  = cap_seq;
        emit_last = 1'b1;
      end
      S_DELIV: begin
        emit_req  = 1'b1;
        emit_kind = KIND_DELIVER;
        emit_tag  = TAG_PORT_W'(cap_tag);
      end
      S_WALK: begin
        emit_req  = walk_more;
        emit_kind = KIND_DELIVER;
        emit_seq  = expected_seq + SEQ_W'(d);
        emit_tag  = TAG_PORT_W'(cell_tag[0]);
      end
      S_ACK: begin
        emit_req   = 1'b1;
        emit_kind  = is_nack ? KIND_NACK : KIND_ACK;
        emit_seq   = is_nack ? cap_seq : expected_seq;
        emit_stamp = cap_stamp;
        emit_last  = 1'b1;
      end
      default: begin
        emit_req = 1'b0;
      end
    endcase
  end

  assign emit_fire  = emit_req && (!ov || out_ch.ready);
  assign do_shift   = emit_fire && ((state == S_DELIV) || (state == S_WALK));
  assign ack_fire   = emit_fire && (state == S_ACK);
  assign shrink     = cap_pw < cur_window;
  assign store_base = (state == S_EVAL) && !closed && cap_wf && in_window &&
                      !cap_trunc && (off != '0);

  // slot chain
  for (genvar i = 0; i < WINDOW_SLOTS; i++) begin : g_cell
    logic                up_full;
    logic [TAG_BITS-1:0] up_tag;

    if (i == WINDOW_SLOTS - 1) begin : g_top
      assign up_full = 1'b0;
      assign up_tag  = '0;
    end else begin : g_mid
      assign up_full = cell_full[i+1];
      assign up_tag  = cell_tag[i+1];
    end

    assign ctrl[i].load  = store_base && (32'(off) == i) && !cell_full[i];
    assign ctrl[i].shift = do_shift;
    assign ctrl[i].clear = ack_fire && shrink && (i >= 32'(cap_pw)) &&
                           (i < 32'(cur_window));

    srrw_cell #(
      .TAG_BITS (TAG_BITS)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl[i]),
      .load_tag (cap_tag),
      .up_full  (up_full),
      .up_tag   (up_tag),
      .full     (cell_full[i]),
      .tag      (cell_tag[i])
    );
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      expected_seq <= '0;
      cur_window   <= MAX_WINDOW_RST;
      closed       <= 1'b0;
      d            <= '0;
      is_nack      <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (closed || !cap_wf) begin
            state <= S_IDLE;
          end else if ((off == '0) && cap_empty) begin
            state <= S_END;
          end else if (!in_window) begin
            state <= S_IDLE;
          end else if (cap_trunc) begin
            is_nack <= 1'b1;
            state   <= S_ACK;
          end else if (off == '0) begin
            is_nack <= 1'b0;
            state   <= S_DELIV;
          end else begin
            is_nack <= 1'b0;
            state   <= S_ACK;
          end
        end
        S_END: begin
          if (emit_fire) begin
            closed <= 1'b1;
            state  <= S_IDLE;
          end
        end
        S_DELIV: begin
          if (emit_fire) begin
            d     <= DW'(1);
            state <= S_WALK;
          end
        end
        S_WALK: begin
          if (!walk_more) begin
            expected_seq <= expected_seq + SEQ_W'(d);
            state        <= S_ACK;
          end else if (emit_fire) begin
            d <= d + DW'(1);
          end
        end
        S_ACK: begin
          if (emit_fire) begin
            if (shrink) begin
              cur_window <= cap_pw;
            end else if ((cur_window < cap_pw) && (cur_window < max_window)) begin
              cur_window <= (cap_pw < max_window) ? cap_pw : max_window;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (emit_fire) begin
      ov <= 1'b1;
    end else if (out_ch.ready) begin
      ov <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      o_kind  <= emit_kind;
      o_seq   <= emit_seq;
      o_tag   <= emit_tag;
      o_stamp <= emit_stamp;
      o_last  <= emit_last;
    end
  end

  assign out_ch.valid      = ov;
  assign out_ch.kind       = o_kind;
  assign out_ch.out_seq    = o_seq;
  assign out_ch.out_tag    = o_tag;
  assign out_ch.out_window = max_window;
  assign out_ch.out_stamp  = o_stamp;
  assign out_ch.last       = o_last;

  a_slot0_empty_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !cell_full[0])
    else $error("slot 0 held while idle");

  a_closed_ignores: assert property (@(posedge clk) disable iff (rst)
    (closed && (state == S_EVAL)) |=> (state == S_IDLE))
    else $error("header processed after connection end");

  a_walk_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) |-> ((d != '0) && (32'(d) <= WINDOW_SLOTS)))
    else $error("walk count out of range");

  a_no_emit_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |=> !(emit_fire && (state == S_WALK)))
    else $error("delivery without expected packet");

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the selective-repeat receive window. Packet headers
// go in on the header channel, from a table of directed headers first and then
// from random phases that fill the window and release it in long in-order
// runs. Every accepted header is run through a bench-side window model; its
// results, or a directed row's own, are queued and compared field by field
// with the result channel; max_window is rewritten between phases over APB
// and read back. Both channels idle at random; the run closes the connection.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import srrw_pkg::*;

  localparam int SLOTS       = WINDOW_SLOTS_DEF;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_WAIT  = 2 * SLOTS + 8;

  typedef struct packed {
    logic                  well_formed;
    logic [SEQ_W-1:0]      seq;
    logic                  empty_req;
    logic                  truncated;
    logic [WIN_W-1:0]      peer_window;
    logic [STAMP_W-1:0]    stamp;
    logic [TAG_PORT_W-1:0] payload_tag;
  } pkt_t;

  typedef struct packed {
    logic [KIND_W-1:0]     kind;
    logic [SEQ_W-1:0]      out_seq;
    logic [TAG_PORT_W-1:0] out_tag;
    logic [WIN_W-1:0]      out_window;
    logic [STAMP_W-1:0]    out_stamp;
    logic                  last;
  } ev_t;

  typedef struct {
    pkt_t p;
    int   n_typed;
    ev_t  ev;
  } plan_row_t;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;

  srrw_in_if  hdr_ch ();
  srrw_out_if res_ch ();

  selective_repeat_receive_window_unit dut (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (hdr_ch),
    .out_ch  (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  logic [SEQ_W-1:0]      next_seq;
  logic [WIN_W-1:0]      win_now;
  logic [WIN_W-1:0]      max_win;
  logic                  held [SLOTS];
  logic [TAG_PORT_W-1:0] held_tag [SLOTS];
  logic                  conn_closed;

  ev_t owed_events [$];
  bit  shadow_only;
  bit  hdr_quiet;
  bit  res_quiet;
  int  errors;
  int  pkts_sent;
  int  events_checked;
  int  peak_results;
  int  res_hold;
  int  cycles;
  plan_row_t plan [$];

  initial clk = 1'b0;
  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic void owe(logic [KIND_W-1:0] kind, logic [SEQ_W-1:0] sq,
                              logic [TAG_PORT_W-1:0] tag, logic [STAMP_W-1:0] stamp,
                              logic last);
    ev_t e;
    e.kind       = kind;
    e.out_seq    = sq;
    e.out_tag    = tag;
    e.out_window = max_win;
    e.out_stamp  = stamp;
    e.last       = last;
    if (!shadow_only) owed_events.push_back(e);
  endfunction

  function automatic void resize_window(logic [WIN_W-1:0] nw);
    if (nw < win_now) begin
      for (int i = nw; i < win_now; i++) held[i] = 1'b0;
      win_now = nw;
    end else if (win_now < nw && win_now < max_win) begin
      win_now = (nw < max_win) ? nw : max_win;
    end
  endfunction

  function automatic void rx_window_step(pkt_t h);
    logic [SEQ_W-1:0] off;
    int d;
    if (conn_closed || !h.well_formed) return;
    off = h.seq - next_seq;
    if (off == 0 && h.empty_req) begin
      conn_closed = 1'b1;
      owe(KIND_END, h.seq, '0, '0, 1'b1);
      return;
    end
    if (off != 0 && (off >= win_now || off >= SLOTS)) return;
    if (h.truncated) begin
      resize_window(h.peer_window);
      owe(KIND_NACK, h.seq, '0, h.stamp, 1'b1);
      return;
    end
    if (off == 0) begin
      owe(KIND_DELIVER, next_seq, h.payload_tag, '0, 1'b0);
      d = 1;
      while (d < win_now && d < SLOTS && held[d]) begin
        owe(KIND_DELIVER, SEQ_W'(next_seq + d), held_tag[d], '0, 1'b0);
        d++;
      end
      for (int i = 0; i < SLOTS; i++) begin
        if (i + d < SLOTS) begin
          held[i]     = held[i + d];
          held_tag[i] = held_tag[i + d];
        end else begin
          held[i] = 1'b0;
        end
      end
      next_seq = SEQ_W'(next_seq + d);
      if (d + 1 > peak_results) peak_results = d + 1;
    end else if (!held[off]) begin
      held[off]     = 1'b1;
      held_tag[off] = h.payload_tag;
    end
    resize_window(h.peer_window);
    owe(KIND_ACK, next_seq, '0, h.stamp, 1'b1);
  endfunction

  function automatic void check_event(ev_t got);
    ev_t want;
    events_checked++;
    if (owed_events.size() == 0) begin
      $error("unexpected result: kind %0d seq %0d", got.kind, got.out_seq);
      errors++;
      return;
    end
    want = owed_events.pop_front();
    if (got.kind != want.kind) begin
      $error("kind: expected %0d, got %0d", want.kind, got.kind);
      errors++;
    end
    if (got.out_seq != want.out_seq) begin
      $error("out_seq: expected %0d, got %0d", want.out_seq, got.out_seq);
      errors++;
    end
    if (got.out_tag != want.out_tag) begin
      $error("out_tag: expected 0x%04h, got 0x%04h", want.out_tag, got.out_tag);
      errors++;
    end
    if (got.out_window != want.out_window) begin
      $error("out_window: expected %0d, got %0d", want.out_window, got.out_window);
      errors++;
    end
    if (got.out_stamp != want.out_stamp) begin
      $error("out_stamp: expected 0x%08h, got 0x%08h", want.out_stamp, got.out_stamp);
      errors++;
    end
    if (got.last != want.last) begin
      $error("last: expected %0d, got %0d", want.last, got.last);
      errors++;
    end
  endfunction

  function automatic int stall_draw(bit quiet);
    return quiet ? 0 : int'($urandom_range(0, 15));
  endfunction

  always @(posedge clk) begin : res_side
    int gap;
    gap = stall_draw(res_quiet);
    if (rst) begin
      res_ch.ready <= 1'b0;
      res_hold     <= 0;
    end else if (res_ch.valid && res_ch.ready) begin
      check_event('{res_ch.kind, res_ch.out_seq, res_ch.out_tag, res_ch.out_window,
                    res_ch.out_stamp, res_ch.last});
      res_hold     <= gap;
      res_ch.ready <= (gap == 0);
    end else if (res_hold > 1) begin
      res_hold <= res_hold - 1;
    end else begin
      res_hold     <= 0;
      res_ch.ready <= 1'b1;
    end
  end

  function automatic void plan_row(logic wf, logic [SEQ_W-1:0] sq, logic empty,
                                   logic trunc, logic [WIN_W-1:0] pw,
                                   logic [STAMP_W-1:0] stamp,
                                   logic [TAG_PORT_W-1:0] tag, int n_typed,
                                   logic [KIND_W-1:0] kind, logic [SEQ_W-1:0] oseq,
                                   logic [STAMP_W-1:0] ostamp);
    plan_row_t r;
    r.p       = '{wf, sq, empty, trunc, pw, stamp, tag};
    r.n_typed = n_typed;
    r.ev      = '{kind, oseq, '0, '0, ostamp, 1'b1};
    plan.push_back(r);
  endfunction

  task automatic send_pkt(pkt_t p, int n_typed, ev_t typed_ev);
    int gap;
    gap = stall_draw(hdr_quiet);
    if (gap > 0) begin
      hdr_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    hdr_ch.well_formed <= p.well_formed;
    hdr_ch.seq         <= p.seq;
    hdr_ch.empty_req   <= p.empty_req;
    hdr_ch.truncated   <= p.truncated;
    hdr_ch.peer_window <= p.peer_window;
    hdr_ch.stamp       <= p.stamp;
    hdr_ch.payload_tag <= p.payload_tag;
    hdr_ch.valid       <= 1'b1;
    do @(posedge clk); while (!hdr_ch.ready);
    pkts_sent++;
    shadow_only = (n_typed >= 0);
    rx_window_step(p);
    shadow_only = 1'b0;
    if (n_typed == 1) begin
      typed_ev.out_window = max_win;
      owed_events.push_back(typed_ev);
    end
  endtask

  task automatic settle();
    hdr_ch.valid <= 1'b0;
    while (owed_events.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic set_max_window(logic [WIN_W-1:0] val);
    logic [APB_DATA_W-1:0] got;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_W'(4 * int'(REG_MAX_WINDOW));
    pwdata  <= APB_DATA_W'(val);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    max_win = val;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got != APB_DATA_W'(val)) begin
      $error("max_window readback: expected %0d, got %0d", val, got);
      errors++;
    end
  endtask

  function automatic pkt_t fresh_pkt();
    pkt_t p;
    p.well_formed = 1'b1;
    p.seq         = next_seq;
    p.empty_req   = 1'($urandom_range(0, 1));
    p.truncated   = 1'b0;
    p.peer_window = 5'd31;
    p.stamp       = $urandom;
    p.payload_tag = TAG_PORT_W'($urandom);
    return p;
  endfunction

  function automatic pkt_t rand_pkt();
    pkt_t p;
    int r;
    int top;
    p   = fresh_pkt();
    r   = $urandom_range(0, 99);
    top = (win_now > 1) ? int'(win_now) - 1 : 0;
    if ($urandom_range(0, 3) == 0) p.peer_window = WIN_W'($urandom);
    if (r < 10) begin
      p.well_formed = 1'($urandom_range(0, 1));
      p.seq         = SEQ_W'($urandom);
      p.truncated   = 1'($urandom_range(0, 1));
    end else if (r < 20) begin
      p.truncated = 1'b1;
      p.seq       = SEQ_W'(next_seq + $urandom_range(0, top));
    end else if (r < 40 || top == 0) begin
      p.seq = next_seq;
    end else begin
      p.seq = SEQ_W'(next_seq + $urandom_range(1, top));
    end
    if (p.seq == next_seq) p.empty_req = 1'b0;
    return p;
  endfunction

  initial begin
    logic [WIN_W-1:0] win_plan [6];
    pkt_t p;
    rst                = 1'b1;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    hdr_ch.valid       = 1'b0;
    hdr_ch.well_formed = 1'b0;
    hdr_ch.seq         = '0;
    hdr_ch.empty_req   = 1'b0;
    hdr_ch.truncated   = 1'b0;
    hdr_ch.peer_window = '0;
    hdr_ch.stamp       = '0;
    hdr_ch.payload_tag = '0;
    next_seq           = '0;
    win_now            = MAX_WINDOW_RST;
    max_win            = MAX_WINDOW_RST;
    conn_closed        = 1'b0;
    shadow_only        = 1'b0;
    hdr_quiet          = 1'b0;
    res_quiet          = 1'b0;
    errors             = 0;
    pkts_sent          = 0;
    events_checked     = 0;
    peak_results       = 0;
    for (int i = 0; i < SLOTS; i++) begin
      held[i]     = 1'b0;
      held_tag[i] = '0;
    end

    plan_row(1'b0,   0, 1'b0, 1'b0,  3, 32'h0000_0001, 16'h0001,  0, KIND_ACK,  0, 0);
    plan_row(1'b1,   0, 1'b0, 1'b0,  3, 32'hFFFF_FFFF, 16'hFFFF, -1, KIND_ACK,  0, 0);
    plan_row(1'b1,   2, 1'b0, 1'b0,  3, 32'h0000_0000, 16'h1234,  1, KIND_ACK,  1, 0);
    plan_row(1'b1,   2, 1'b0, 1'b0,  3, 32'h0000_0005, 16'hBEEF,  1, KIND_ACK,  1, 5);
    plan_row(1'b1,   3, 1'b0, 1'b0,  3, 32'h0000_0006, 16'h00FF,  1, KIND_ACK,  1, 6);
    plan_row(1'b1,   4, 1'b0, 1'b0,  3, 32'h0000_0007, 16'h0000,  0, KIND_ACK,  0, 0);
    plan_row(1'b1, 255, 1'b0, 1'b0, 31, 32'h0000_0008, 16'h0000,  0, KIND_ACK,  0, 0);
    plan_row(1'b1,   1, 1'b0, 1'b1,  3, 32'h0000_0009, 16'h0000,  1, KIND_NACK, 1, 9);
    plan_row(1'b1,   1, 1'b0, 1'b0,  3, 32'h0000_000A, 16'h0000, -1, KIND_ACK,  0, 0);
    plan_row(1'b1,   5, 1'b0, 1'b0,  0, 32'h0000_000B, 16'h5555,  1, KIND_ACK,  4, 11);
    plan_row(1'b1,   5, 1'b0, 1'b0,  0, 32'h0000_000C, 16'h0000,  0, KIND_ACK,  0, 0);
    plan_row(1'b1,   4, 1'b0, 1'b0,  0, 32'h0000_000D, 16'hAAAA, -1, KIND_ACK,  0, 0);
    plan_row(1'b1,   5, 1'b0, 1'b1, 31, 32'h0000_000E, 16'h0000,  1, KIND_NACK, 5, 14);
    plan_row(1'b1,   6, 1'b1, 1'b0,  2, 32'h0000_000F, 16'h8001,  1, KIND_ACK,  5, 15);
    plan_row(1'b1,   5, 1'b0, 1'b0,  3, 32'h8000_0000, 16'h7FFF, -1, KIND_ACK,  0, 0);
    plan_row(1'b1,   7, 1'b0, 1'b0, 31, 32'h0000_0010, 16'hFFFF, -1, KIND_ACK,  0, 0);

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) send_pkt(plan[i].p, plan[i].n_typed, plan[i].ev);
    settle();

    win_plan = '{5'd31, 5'd0, 5'd1, WIN_W'($urandom_range(2, 30)), 5'd31, 5'd2};
    foreach (win_plan[ph]) begin
      set_max_window(win_plan[ph]);
      hdr_quiet = (ph == 1) || (ph == 4);
      res_quiet = (ph == 2) || (ph == 4);
      // open the window fully, fill it back to front, then release it
      p = fresh_pkt();
      p.empty_req = 1'b0;
      send_pkt(p, -1, '0);
      for (int k = int'(win_now) - 1; k >= 1; k--) begin
        p = fresh_pkt();
        p.seq = SEQ_W'(next_seq + k);
        send_pkt(p, -1, '0);
      end
      p = fresh_pkt();
      p.empty_req = 1'b0;
      send_pkt(p, -1, '0);
      while (pkts_sent < 16 + 50 * (ph + 1)) begin
        if (ph == 2 && pkts_sent == 16 + 50 * ph + 25) settle();
        send_pkt(rand_pkt(), -1, '0);
      end
      settle();
    end

    // close the connection; later headers must be dropped
    p = fresh_pkt();
    p.empty_req = 1'b1;
    p.truncated = 1'b1;
    send_pkt(p, -1, '0);
    repeat (4) begin
      p = rand_pkt();
      p.empty_req = 1'($urandom_range(0, 1));
      send_pkt(p, -1, '0);
    end
    settle();

    $display("Sent %0d packet headers over 7 max_window settings, checked %0d results",
             pkts_sent, events_checked);
    $display("Longest in-order release: %0d results for one header", peak_results);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
